/* sv/sit_pkg.sv */
// Shared types for the segment intersection test pipeline.
package sit_pkg;

  typedef enum logic [1:0] {
    ORIENT_COLLINEAR = 2'd0,
    ORIENT_POS       = 2'd1,
    ORIENT_NEG       = 2'd2
  } orient_e;

  // Per-pair flags from the front stage; box[k] pairs with orientation k.
  typedef struct packed {
    logic       adjacent;
    logic [3:0] box;
  } sit_flags_t;

endpackage

/* sv/sit_diff_stage.sv */
// Front stage: coordinate differences, adjacency and bounding box flags.
module sit_diff_stage
  import sit_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int DIFF_WIDTH  = 33
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic signed [COORD_WIDTH-1:0] ax_i,
  input  logic signed [COORD_WIDTH-1:0] ay_i,
  input  logic signed [COORD_WIDTH-1:0] bx_i,
  input  logic signed [COORD_WIDTH-1:0] by_i,
  input  logic signed [COORD_WIDTH-1:0] cx_i,
  input  logic signed [COORD_WIDTH-1:0] cy_i,
  input  logic signed [COORD_WIDTH-1:0] dx_i,
  input  logic signed [COORD_WIDTH-1:0] dy_i,
  output logic                          valid_o,
  output logic signed [DIFF_WIDTH-1:0]  term_o [4][4],
  output sit_flags_t                    flags_o
);

  logic signed [COORD_WIDTH-1:0] px [4];
  logic signed [COORD_WIDTH-1:0] py [4];
  logic signed [COORD_WIDTH-1:0] qx [4];
  logic signed [COORD_WIDTH-1:0] qy [4];
  logic signed [COORD_WIDTH-1:0] rx [4];
  logic signed [COORD_WIDTH-1:0] ry [4];
  logic signed [DIFF_WIDTH-1:0]  term_d [4][4];
  logic signed [DIFF_WIDTH-1:0]  term_q [4][4];
  sit_flags_t                    flags_d, flags_q;
  logic                          valid_q;
  logic                          ac, bd, ad, bc;

  always_comb begin
    // Point triples of the four orientation tests.
    px[0] = ax_i; py[0] = ay_i; qx[0] = bx_i; qy[0] = by_i; rx[0] = cx_i; ry[0] = cy_i;
    px[1] = ax_i; py[1] = ay_i; qx[1] = bx_i; qy[1] = by_i; rx[1] = dx_i; ry[1] = dy_i;
    px[2] = cx_i; py[2] = cy_i; qx[2] = dx_i; qy[2] = dy_i; rx[2] = ax_i; ry[2] = ay_i;
    px[3] = cx_i; py[3] = cy_i; qx[3] = dx_i; qy[3] = dy_i; rx[3] = bx_i; ry[3] = by_i;

    for (int k = 0; k < 4; k++) begin
      term_d[k][0] = DIFF_WIDTH'(qy[k]) - DIFF_WIDTH'(py[k]);
      term_d[k][1] = DIFF_WIDTH'(rx[k]) - DIFF_WIDTH'(qx[k]);
      term_d[k][2] = DIFF_WIDTH'(qx[k]) - DIFF_WIDTH'(px[k]);
      term_d[k][3] = DIFF_WIDTH'(ry[k]) - DIFF_WIDTH'(qy[k]);
      // r inside the box of p and q, borders included.
      flags_d.box[k] = (rx[k] <= px[k] || rx[k] <= qx[k]) &&
                       (px[k] <= rx[k] || qx[k] <= rx[k]) &&
                       (ry[k] <= py[k] || ry[k] <= qy[k]) &&
                       (py[k] <= ry[k] || qy[k] <= ry[k]);
    end

    ac = (ax_i == cx_i) && (ay_i == cy_i);
    bd = (bx_i == dx_i) && (by_i == dy_i);
    ad = (ax_i == dx_i) && (ay_i == dy_i);
    bc = (bx_i == cx_i) && (by_i == cy_i);
    flags_d.adjacent = (ac && !bd) || (ad && !bc) || (bc && !ad) || (bd && !ac);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    term_q  <= term_d;
    flags_q <= flags_d;
  end

  assign valid_o = valid_q;
  assign term_o  = term_q;
  assign flags_o = flags_q;

endmodule

/* sv/sit_orient.sv */
// Orientation unit: split products, recombine, subtract and take the sign.
module sit_orient
  import sit_pkg::*;
#(
  parameter int DIFF_WIDTH = 33
) (
  input  logic                         clk_i,
  input  logic signed [DIFF_WIDTH-1:0] m1a_i,
  input  logic signed [DIFF_WIDTH-1:0] m1b_i,
  input  logic signed [DIFF_WIDTH-1:0] m2a_i,
  input  logic signed [DIFF_WIDTH-1:0] m2b_i,
  output orient_e                      orient_o
);

  localparam int LoW  = DIFF_WIDTH / 2;
  localparam int HiW  = DIFF_WIDTH - LoW;
  localparam int ProdW = 2 * DIFF_WIDTH;

  typedef struct packed {
    logic        [2*LoW-1:0]  ll;
    logic signed [LoW+HiW:0]  lh;
    logic signed [LoW+HiW:0]  hl;
    logic signed [2*HiW-1:0]  hh;
  } part_t;

  part_t                    part1_d, part2_d, part1_q, part2_q;
  logic signed [ProdW-1:0]  m1_d, m2_d, m1_q, m2_q;
  logic signed [ProdW:0]    diff;
  orient_e                  orient_d, orient_q;

  function automatic part_t split_mul(logic signed [DIFF_WIDTH-1:0] a,
                                      logic signed [DIFF_WIDTH-1:0] b);
    part_t p;
    p.ll = (2*LoW)'(a[LoW-1:0]) * (2*LoW)'(b[LoW-1:0]);
    p.lh = (LoW+HiW+1)'($signed({1'b0, a[LoW-1:0]})) *
           (LoW+HiW+1)'($signed(b[DIFF_WIDTH-1:LoW]));
    p.hl = (LoW+HiW+1)'($signed(a[DIFF_WIDTH-1:LoW])) *
           (LoW+HiW+1)'($signed({1'b0, b[LoW-1:0]}));
    p.hh = (2*HiW)'($signed(a[DIFF_WIDTH-1:LoW])) *
           (2*HiW)'($signed(b[DIFF_WIDTH-1:LoW]));
    return p;
  endfunction

  function automatic logic signed [ProdW-1:0] join_parts(part_t p);
    logic signed [ProdW-1:0] hh_w, mid_w, ll_w;
    hh_w  = ProdW'(p.hh);
    mid_w = ProdW'(p.lh) + ProdW'(p.hl);
    ll_w  = ProdW'(p.ll);
    return (hh_w << (2 * LoW)) + (mid_w << LoW) + ll_w;
  endfunction

  always_comb begin
    part1_d = split_mul(m1a_i, m1b_i);
    part2_d = split_mul(m2a_i, m2b_i);
    m1_d    = join_parts(part1_q);
    m2_d    = join_parts(part2_q);
    diff    = (ProdW + 1)'(m1_q) - (ProdW + 1)'(m2_q);
    if (diff == '0) begin
      orient_d = ORIENT_COLLINEAR;
    end else if (diff[ProdW]) begin
      orient_d = ORIENT_NEG;
    end else begin
      orient_d = ORIENT_POS;
    end
  end

  // Partial products, recombined products, orientation code.
  always_ff @(posedge clk_i) begin
    part1_q  <= part1_d;
    part2_q  <= part2_d;
    m1_q     <= m1_d;
    m2_q     <= m2_d;
    orient_q <= orient_d;
  end

  assign orient_o = orient_q;

endmodule

/* sv/sit_decide.sv */
// Final stage: combine orientation codes and flags into the result bit.
module sit_decide
  import sit_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  orient_e    orient_i [4],
  input  sit_flags_t flags_i,
  output logic       valid_o,
  output logic       cross_o
);

  logic       valid_q;
  logic       cross_d, cross_q;
  logic [3:0] touch;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      touch[k] = (orient_i[k] == ORIENT_COLLINEAR) && flags_i.box[k];
    end
    cross_d = !flags_i.adjacent &&
              (((orient_i[0] != orient_i[1]) && (orient_i[2] != orient_i[3])) ||
               (|touch));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cross_q <= cross_d;
  end

  assign valid_o = valid_q;
  assign cross_o = cross_q;

endmodule

/* sv/segment_intersection_test.sv */
// Top level of the segment intersection test pipeline.
//
//   channel   direction  handshake               word
//   command   in         start_i, busy_o         eight endpoint coordinates
//   result    out        done_o (one-cycle pulse) segments_cross_o
//
// A pair enters at every edge where start_i is high; busy_o is held low, since
// nothing downstream can stall. The result strobes on done_o after the stages:
// one stage for differences and compares, three in each orientation unit
// (split partial products, recombine, subtract and sign), one to decide.
// Reset clears only the valid bits; data registers just follow them.
module segment_intersection_test
  import sit_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COORD_WIDTH-1:0] first_start_x_i,
  input  logic signed [COORD_WIDTH-1:0] first_start_y_i,
  input  logic signed [COORD_WIDTH-1:0] first_end_x_i,
  input  logic signed [COORD_WIDTH-1:0] first_end_y_i,
  input  logic signed [COORD_WIDTH-1:0] second_start_x_i,
  input  logic signed [COORD_WIDTH-1:0] second_start_y_i,
  input  logic signed [COORD_WIDTH-1:0] second_end_x_i,
  input  logic signed [COORD_WIDTH-1:0] second_end_y_i,
  output logic                          done_o,
  output logic                          segments_cross_o
);

  // One extra bit keeps every coordinate difference exact.
  localparam int DiffW    = COORD_WIDTH + 1;
  // Register stages in one orientation unit.
  localparam int OrientLat = 3;

  logic                    accept;
  logic                    valid_a;
  logic signed [DiffW-1:0] term_a [4][4];
  sit_flags_t              flags_a;
  orient_e                 orient_c [4];

  // Delay line that carries valid and flags alongside the orientation units.
  logic       valid_q [OrientLat];
  sit_flags_t flags_q [OrientLat];

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  sit_diff_stage #(
    .COORD_WIDTH (COORD_WIDTH),
    .DIFF_WIDTH  (DiffW)
  ) u_diff (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .ax_i    (first_start_x_i),
    .ay_i    (first_start_y_i),
    .bx_i    (first_end_x_i),
    .by_i    (first_end_y_i),
    .cx_i    (second_start_x_i),
    .cy_i    (second_start_y_i),
    .dx_i    (second_end_x_i),
    .dy_i    (second_end_y_i),
    .valid_o (valid_a),
    .term_o  (term_a),
    .flags_o (flags_a)
  );

  // Four orientations: (a,b,c), (a,b,d), (c,d,a), (c,d,b).
  for (genvar k = 0; k < 4; k++) begin : g_orient
    sit_orient #(
      .DIFF_WIDTH (DiffW)
    ) u_orient (
      .clk_i    (clk_i),
      .m1a_i    (term_a[k][0]),
      .m1b_i    (term_a[k][1]),
      .m2a_i    (term_a[k][2]),
      .m2b_i    (term_a[k][3]),
      .orient_o (orient_c[k])
    );
  end

  // Advance valid bits; clear them on reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < OrientLat; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else begin
      valid_q[0] <= valid_a;
      for (int i = 1; i < OrientLat; i++) begin
        valid_q[i] <= valid_q[i-1];
      end
    end
  end

  // Advance flags in step with the valid bits.
  always_ff @(posedge clk_i) begin
    flags_q[0] <= flags_a;
    for (int i = 1; i < OrientLat; i++) begin
      flags_q[i] <= flags_q[i-1];
    end
  end

  sit_decide u_decide (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_q[OrientLat-1]),
    .orient_i (orient_c),
    .flags_i  (flags_q[OrientLat-1]),
    .valid_o  (done_o),
    .cross_o  (segments_cross_o)
  );

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the segment intersection test pipeline.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sit_pkg::*;

  localparam int     COORD_WIDTH = 32;
  localparam longint ONE         = 64'sd65536;        // 1.0 in Q15.16
  localparam longint COORD_MAX   = 64'sd2147483647;
  localparam longint COORD_MIN   = -64'sd2147483648;
  localparam int     RANDOM_PAIRS = 1100;
  localparam int     SETTLE_CYCLES = 12;              // five-stage pipe plus margin
  localparam int     CYCLE_LIMIT = 200000;

  // One command word: both segments, plus a flag that makes the driver
  // hold this word back until every outstanding result has come home.
  typedef struct packed {
    logic                          hold_for_drain;
    logic signed [COORD_WIDTH-1:0] ax, ay;            // first segment start
    logic signed [COORD_WIDTH-1:0] bx, by;            // first segment end
    logic signed [COORD_WIDTH-1:0] cx, cy;            // second segment start
    logic signed [COORD_WIDTH-1:0] dx, dy;            // second segment end
  } segment_pair_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic done_o;
  logic segments_cross_o;

  segment_pair_t on_wire = '0;      // word currently presented on the command ports
  segment_pair_t pair_q[$];         // words still to be sent
  bit            cross_expect_q[$]; // predicted segments_cross per accepted word
  logic          word_taken = 1'b0; // the word on the ports was accepted at the last edge
  int unsigned   gap_left = 0;
  int unsigned   calm_left = 0;
  int unsigned   results_seen = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;

  segment_intersection_test #(
    .COORD_WIDTH(COORD_WIDTH)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .first_start_x_i  (on_wire.ax),
    .first_start_y_i  (on_wire.ay),
    .first_end_x_i    (on_wire.bx),
    .first_end_y_i    (on_wire.by),
    .second_start_x_i (on_wire.cx),
    .second_start_y_i (on_wire.cy),
    .second_end_x_i   (on_wire.dx),
    .second_end_y_i   (on_wire.dy),
    .done_o           (done_o),
    .segments_cross_o (segments_cross_o)
  );

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Turn of the path p -> q -> r. The two products need up to 66 bits, so
  // evaluate everything at 128 bits where nothing can overflow.
  function automatic orient_e orientation_of(input longint px, py, qx, qy, rx, ry);
    logic signed [127:0] dy_pq, dx_qr, dx_pq, dy_qr, det;
    dy_pq = 128'(qy) - 128'(py);
    dx_qr = 128'(rx) - 128'(qx);
    dx_pq = 128'(qx) - 128'(px);
    dy_qr = 128'(ry) - 128'(qy);
    det   = dy_pq * dx_qr - dx_pq * dy_qr;
    if (det == 0) return ORIENT_COLLINEAR;
    return det[127] ? ORIENT_NEG : ORIENT_POS;
  endfunction

  // q lies in the closed bounding box spanned by p and r.
  function automatic bit within_box(input longint px, py, qx, qy, rx, ry);
    return (qx <= ((px > rx) ? px : rx)) && (qx >= ((px < rx) ? px : rx)) &&
           (qy <= ((py > ry) ? py : ry)) && (qy >= ((py < ry) ? py : ry));
  endfunction

  function automatic bit segments_cross_of(input segment_pair_t p);
    longint  ax, ay, bx, by, cx, cy, dx, dy;
    bit      ac, bd, ad, bc;
    orient_e o1, o2, o3, o4;
    ax = $signed(p.ax); ay = $signed(p.ay);
    bx = $signed(p.bx); by = $signed(p.by);
    cx = $signed(p.cx); cy = $signed(p.cy);
    dx = $signed(p.dx); dy = $signed(p.dy);
    ac = (ax == cx) && (ay == cy);
    bd = (bx == dx) && (by == dy);
    ad = (ax == dx) && (ay == dy);
    bc = (bx == cx) && (by == cy);
    // Adjacent edges: exactly one shared endpoint means no intersection.
    // Identical segments (either order) fall through to the full test.
    if ((ac && !bd) || (ad && !bc) || (bc && !ad) || (bd && !ac)) return 1'b0;
    o1 = orientation_of(ax, ay, bx, by, cx, cy);
    o2 = orientation_of(ax, ay, bx, by, dx, dy);
    o3 = orientation_of(cx, cy, dx, dy, ax, ay);
    o4 = orientation_of(cx, cy, dx, dy, bx, by);
    return (o1 != o2 && o3 != o4) ||
           (o1 == ORIENT_COLLINEAR && within_box(ax, ay, cx, cy, bx, by)) ||
           (o2 == ORIENT_COLLINEAR && within_box(ax, ay, dx, dy, bx, by)) ||
           (o3 == ORIENT_COLLINEAR && within_box(cx, cy, ax, ay, dx, dy)) ||
           (o4 == ORIENT_COLLINEAR && within_box(cx, cy, bx, by, dx, dy));
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------

  // Pack eight coordinates into a word; values wrap to the port width.
  function automatic segment_pair_t pair_of(input longint ax, ay, bx, by,
                                            cx, cy, dx, dy);
    segment_pair_t p;
    p = '0;
    p.ax = COORD_WIDTH'(ax); p.ay = COORD_WIDTH'(ay);
    p.bx = COORD_WIDTH'(bx); p.by = COORD_WIDTH'(by);
    p.cx = COORD_WIDTH'(cx); p.cy = COORD_WIDTH'(cy);
    p.dx = COORD_WIDTH'(dx); p.dy = COORD_WIDTH'(dy);
    return p;
  endfunction

  // Append a word to the send queue.
  task automatic enqueue_word(input segment_pair_t p);
    pair_q = {pair_q, p};
  endtask

  // Random pair from one of several shapes. Coordinates default to a small
  // grid at a random scale, which makes collinear and touching cases common;
  // the other shapes build shared endpoints, overlaps, points and crossings.
  function automatic segment_pair_t random_pair();
    longint      c[8];
    longint      scale, ox, oy, vx, vy, k, tmp;
    int unsigned slot, src;
    scale = longint'(1) << (7 * $urandom_range(0, 4));
    foreach (c[i]) c[i] = (longint'($urandom_range(0, 8)) - 4) * scale;
    vx = (longint'($urandom_range(0, 8)) - 4) * scale;
    vy = (longint'($urandom_range(0, 8)) - 4) * scale;
    case ($urandom_range(0, 9))
      0, 1: begin
        // full-range noise: toggles every coordinate bit
        foreach (c[i]) c[i] = longint'($signed($urandom()));
      end
      2, 3: begin
        // keep the plain grid draw
      end
      4: begin
        // all four endpoints on one line: overlap, containment or a gap
        ox = c[0];
        oy = c[1];
        for (int j = 0; j < 4; j++) begin
          k = longint'($urandom_range(0, 8)) - 4;
          c[2*j]   = ox + k * vx;
          c[2*j+1] = oy + k * vy;
        end
      end
      5: begin
        // copy one endpoint of the first segment into the second,
        // sometimes both, which turns adjacency into identity
        src  = $urandom_range(0, 1);
        slot = $urandom_range(2, 3);
        c[2*slot]   = c[2*src];
        c[2*slot+1] = c[2*src+1];
        if ($urandom_range(0, 3) == 0) begin
          c[2*(5-slot)]   = c[2*(1-src)];
          c[2*(5-slot)+1] = c[2*(1-src)+1];
        end
      end
      6: begin
        // identical segments, same or reversed order
        if ($urandom_range(0, 1) == 0) begin
          for (int j = 0; j < 4; j++) c[4+j] = c[j];
        end else begin
          c[4] = c[2]; c[5] = c[3]; c[6] = c[0]; c[7] = c[1];
        end
      end
      7: begin
        // a single point, mostly on the first segment's line, inside or past its ends
        c[2] = c[0] + 2 * vx;
        c[3] = c[1] + 2 * vy;
        if ($urandom_range(0, 2) != 0) begin
          k = longint'($urandom_range(0, 4)) - 1;
          c[4] = c[0] + k * vx;
          c[5] = c[1] + k * vy;
        end
        c[6] = c[4];
        c[7] = c[5];
        if ($urandom_range(0, 1) == 0) begin
          // swap segments so the point is the first one
          for (int j = 0; j < 4; j++) begin
            tmp    = c[j];
            c[j]   = c[4+j];
            c[4+j] = tmp;
          end
        end
      end
      8: begin
        // two segments through a common center; a short or reversed second
        // half gives near misses and touches
        ox = longint'($signed($urandom())) >>> $urandom_range(1, 31);
        oy = longint'($signed($urandom())) >>> $urandom_range(1, 31);
        k  = longint'($urandom_range(0, 4)) - 2;
        c[0] = ox - vx;     c[1] = oy - vy;
        c[2] = ox + vx;     c[3] = oy + vy;
        c[4] = ox - c[5];   c[5] = oy - c[4];
        c[6] = ox + k * (ox - c[4]);
        c[7] = oy + k * (oy - c[5]);
      end
      default: begin
        // corners of the coordinate range
        foreach (c[i]) begin
          case ($urandom_range(0, 7))
            0:       c[i] = COORD_MIN;
            1:       c[i] = COORD_MAX;
            2:       c[i] = 0;
            3:       c[i] = -1;
            4:       c[i] = 1;
            5:       c[i] = COORD_MIN + 1;
            6:       c[i] = COORD_MAX - 1;
            default: c[i] = longint'($signed($urandom()));
          endcase
        end
      end
    endcase
    return pair_of(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] ERROR %s", $time, what);
  endtask

  // ---------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hold reset, then release it on a falling edge.
  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Free-running watchdog: a hung pipe or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("segment_intersection_test: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Driver: present words on the falling edge
  // ---------------------------------------------------------------------
  // A word stays on the ports until an edge sees start_i high with busy_o
  // low. After each accepted word, idle for a drawn number of cycles; now
  // and then run a calm stretch back to back so the pipe fills completely.
  always @(negedge clk_i) begin : driver
    if (rst_ni && !(start_i && !word_taken)) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start_i  <= 1'b0;
      end else if (pair_q.size() != 0 &&
                   !(pair_q[0].hold_for_drain && cross_expect_q.size() != 0)) begin
        on_wire <= pair_q.pop_front();
        start_i <= 1'b1;
        if (calm_left != 0) begin
          calm_left <= calm_left - 1;
          gap_left  <= 0;
        end else if ($urandom_range(0, 15) == 0) begin
          calm_left <= $urandom_range(10, 40);
          gap_left  <= 0;
        end else begin
          gap_left <= $urandom_range(0, 18);
        end
      end else begin
        // nothing to send, or draining before a held-back word
        start_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: sample on the rising edge
  // ---------------------------------------------------------------------
  // Check the strobed result against the oldest prediction first, then
  // predict the word accepted at this same edge.
  always @(posedge clk_i) begin : monitor
    bit want;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        results_seen++;
        if (cross_expect_q.size() == 0) begin
          report_mismatch($sformatf("result %0d: segments_cross_o=%b with no word outstanding",
                                    results_seen, segments_cross_o));
        end else begin
          want = cross_expect_q.pop_front();
          if (segments_cross_o !== want)
            report_mismatch($sformatf("result %0d: segments_cross_o=%b, predicted %b",
                                      results_seen, segments_cross_o, want));
        end
      end
      if (start_i && busy_o === 1'b0)
        cross_expect_q = {cross_expect_q, segments_cross_of(on_wire)};
    end
    word_taken <= rst_ni && start_i && busy_o === 1'b0;
  end

  // ---------------------------------------------------------------------
  // Sequence: directed words, random words, drain, verdict
  // ---------------------------------------------------------------------
  initial begin : sequence_ctl
    segment_pair_t p;

    // proper crossing of two diagonals
    enqueue_word(pair_of(0, 0, 4*ONE, 4*ONE, 0, 4*ONE, 4*ONE, 0));
    // parallel, apart
    enqueue_word(pair_of(0, 0, 4*ONE, 0, 0, ONE, 4*ONE, ONE));
    // collinear, overlapping
    enqueue_word(pair_of(0, 0, 4*ONE, 0, 2*ONE, 0, 6*ONE, 0));
    // collinear, disjoint
    enqueue_word(pair_of(0, 0, ONE, 0, 2*ONE, 0, 3*ONE, 0));
    // adjacent edges through each pairing of shared endpoints
    enqueue_word(pair_of(0, 0, 2*ONE, 2*ONE, 0, 0, -2*ONE, 3*ONE));
    enqueue_word(pair_of(ONE, ONE, 3*ONE, -ONE, 5*ONE, 2*ONE, ONE, ONE));
    enqueue_word(pair_of(0, 0, ONE, ONE, ONE, ONE, 2*ONE, 2*ONE));
    enqueue_word(pair_of(0, 0, 2*ONE, 0, 2*ONE, 2*ONE, 2*ONE, 0));
    // identical segments, same and reversed order
    enqueue_word(pair_of(0, 0, 3*ONE, ONE, 0, 0, 3*ONE, ONE));
    enqueue_word(pair_of(0, 0, 3*ONE, ONE, 3*ONE, ONE, 0, 0));
    // T junction: an endpoint touching the other segment's interior
    enqueue_word(pair_of(0, 0, 4*ONE, 0, 2*ONE, 0, 2*ONE, 3*ONE));
    // single point: on the segment, off its line, on its line past the end
    enqueue_word(pair_of(0, 0, 4*ONE, 4*ONE, 2*ONE, 2*ONE, 2*ONE, 2*ONE));
    enqueue_word(pair_of(0, 0, 4*ONE, 4*ONE, 2*ONE, ONE, 2*ONE, ONE));
    enqueue_word(pair_of(0, 0, ONE, ONE, 3*ONE, 3*ONE, 3*ONE, 3*ONE));
    // two points, equal and distinct
    enqueue_word(pair_of(ONE, -ONE, ONE, -ONE, ONE, -ONE, ONE, -ONE));
    enqueue_word(pair_of(ONE, ONE, ONE, ONE, 2*ONE, ONE, 2*ONE, ONE));
    // full-range diagonals and full-range parallels
    enqueue_word(pair_of(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                         COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
    enqueue_word(pair_of(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN,
                         COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
    // every coordinate at one extreme
    enqueue_word(pair_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                         COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    enqueue_word(pair_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                         COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    // one-LSB crossing around the origin
    enqueue_word(pair_of(-1, -1, 0, 0, -1, 0, 0, -1));
    // long segments that miss by less than two LSBs near the origin
    enqueue_word(pair_of(COORD_MIN, 0, COORD_MAX, 1, 0, 2, 0, COORD_MAX));

    // The first random word waits for an empty pipe; a few more do later.
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      p = random_pair();
      if (n == 0 || $urandom_range(0, 149) == 0) p.hold_for_drain = 1'b1;
      enqueue_word(p);
    end

    // Drain: every word sent and accepted, every prediction checked against a result.
    do @(posedge clk_i);
    while (pair_q.size() != 0 || start_i || cross_expect_q.size() != 0);
    // Let the pipe run on so a stray late strobe is caught.
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("segment_intersection_test: match");
    end else begin
      $display("segment_intersection_test: mismatch");
    end
    $finish;
  end

endmodule
